### rtl/core/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// No dependencies; include once per file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define S16_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("s16fr assertion failed");

// Next-cycle implication, disabled while reset is low.
`define S16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("s16fr assertion failed");

`endif

### rtl/core/s16fr_pkg.sv
// Shared types and constants of the sum16 frame receiver.
// No dependencies; used through scoped names by all modules but the input stage.
`default_nettype none

package s16fr_pkg;

  // Frame byte codes
  localparam logic [7:0] START_CODE       = 8'h3A;
  localparam logic [7:0] CMD_OPERATION    = 8'h52;
  localparam logic [7:0] BATTERY_LOW_CODE = 8'h40;

  // Frame position of the first captured data byte, and capture depth
  localparam logic [7:0] CAP_FIRST_POS = 8'd5;
  localparam logic [7:0] CAP_LAST_POS  = 8'd10;
  localparam int         CAP_DEPTH     = 6;

  // Fixed frame positions
  localparam logic [7:0] POS_COMMAND = 8'd3;
  localparam logic [7:0] POS_LENGTH  = 8'd4;

  typedef enum logic [1:0] {
    STATUS_DECODED  = 2'd0,
    STATUS_OTHER    = 2'd1,
    STATUS_CSUM_ERR = 2'd2,
    STATUS_SIZE_ERR = 2'd3
  } status_t;

  typedef enum logic {
    PH_HUNT  = 1'b0,
    PH_FRAME = 1'b1
  } phase_t;

  typedef struct packed {
    status_t     frame_status;
    logic [7:0]  command_code;
    logic        battery_low;
    logic [15:0] current_tenths;
    logic [15:0] wheel_period_ms;
    logic [7:0]  fault_code;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/sum16_frame_receiver_decoder.sv
// Sum16 frame receiver: takes serial bytes one per transfer, hunts for the start
// code 0x3A, checks a 16-bit additive sum and emits one result per frame. It
// accepts a byte in every cycle while results are taken; the byte that ends the
// frame passes the input register and its result is then loaded into the result
// register. Rate is set only by the result register: while a result waits
// untaken, the input register takes at most one more byte and then holds it
// until the result is taken. Frames longer than MAX_FRAME bytes end early with a
// size error at the length byte. Depends on s16fr_pkg and the stage modules.
`default_nettype none

module sum16_frame_receiver_decoder #(
  parameter int MAX_FRAME = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_frame_status,
  output logic [7:0]       out_command_code,
  output logic             out_battery_low,
  output logic [15:0]      out_current_tenths,
  output logic [15:0]      out_wheel_period_ms,
  output logic [7:0]       out_fault_code
);

  logic               byte_vld;
  logic [7:0]         byte_q;
  logic               out_free;
  logic               advance;
  logic               res_valid;
  s16fr_pkg::result_t res;
  s16fr_pkg::result_t res_q;

  // Byte moves into the parser when the result side can take its outcome
  assign advance = byte_vld && out_free;

  s16fr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .advance_i  (advance),
    .vld_o      (byte_vld),
    .byte_o     (byte_q)
  );

  s16fr_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_i      (advance),
    .byte_i      (byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  s16fr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (res_valid),
    .res_i     (res),
    .free_o    (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_o     (res_q)
  );

  // Result fields onto the ports
  assign out_frame_status    = res_q.frame_status;
  assign out_command_code    = res_q.command_code;
  assign out_battery_low     = res_q.battery_low;
  assign out_current_tenths  = res_q.current_tenths;
  assign out_wheel_period_ms = res_q.wheel_period_ms;
  assign out_fault_code      = res_q.fault_code;

endmodule

`default_nettype wire

### rtl/core/s16fr_in_stage.sv
// Input register of the sum16 frame receiver: holds one received byte.
// Depends on nothing but the advance strobe from the top level.
`default_nettype none

module s16fr_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       advance_i,
  output logic            vld_o,
  output logic [7:0]      byte_o
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;

  // Free when empty or when the held byte moves on this cycle
  assign in_ready = !vld_r || advance_i;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (advance_i) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Byte register, loaded on each transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

  assign vld_o  = vld_r;
  assign byte_o = byte_r;

endmodule

`default_nettype wire

### rtl/core/s16fr_parser.sv
// Frame parser: hunt state, position counter, running sum and data capture.
// Depends on s16fr_pkg; produces at most one result per stepped byte.
`default_nettype none

module s16fr_parser #(
  parameter int MAX_FRAME = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  output logic            res_valid_o,
  output s16fr_pkg::result_t res_o
);

  localparam int         MaxLenInt = MAX_FRAME - 9;
  localparam logic [7:0] MaxLen    = 8'(MaxLenInt);

  s16fr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [15:0] rsum_r, rsum_nxt;
  logic [7:0]  cap_r   [s16fr_pkg::CAP_DEPTH];
  logic [7:0]  cap_nxt [s16fr_pkg::CAP_DEPTH];

  logic [7:0] n_eff;
  logic [8:0] pos9;
  logic [8:0] n9;
  logic       start_hit;
  logic       size_err;
  logic       frame_end;
  logic       in_cap;
  logic [2:0] cap_idx;

  // Frame decode conditions for the byte at hand
  assign n_eff     = (idx_r == s16fr_pkg::POS_LENGTH) ? byte_i : len_r;
  assign pos9      = {1'b0, idx_r};
  assign n9        = {1'b0, n_eff};
  assign start_hit = (phase_r == s16fr_pkg::PH_HUNT) && (byte_i == s16fr_pkg::START_CODE);
  assign size_err  = (phase_r == s16fr_pkg::PH_FRAME) &&
                     (idx_r == s16fr_pkg::POS_LENGTH) && (byte_i > MaxLen);
  assign frame_end = (phase_r == s16fr_pkg::PH_FRAME) && !size_err &&
                     (pos9 >= n9 + 9'd8);
  assign in_cap    = (idx_r >= s16fr_pkg::CAP_FIRST_POS) &&
                     (idx_r <= s16fr_pkg::CAP_LAST_POS);
  assign cap_idx   = 3'(idx_r - s16fr_pkg::CAP_FIRST_POS);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      s16fr_pkg::PH_HUNT: begin
        if (step_i && start_hit) begin
          phase_nxt = s16fr_pkg::PH_FRAME;
        end
      end
      s16fr_pkg::PH_FRAME: begin
        if (step_i && (size_err || frame_end)) begin
          phase_nxt = s16fr_pkg::PH_HUNT;
        end
      end
      default: phase_nxt = s16fr_pkg::PH_HUNT;
    endcase
  end

  // Counter, length, command, sums and capture
  always_comb begin
    idx_nxt  = idx_r;
    len_nxt  = len_r;
    cmd_nxt  = cmd_r;
    sum_nxt  = sum_r;
    rsum_nxt = rsum_r;
    cap_nxt  = cap_r;
    if (step_i) begin
      if (phase_r == s16fr_pkg::PH_HUNT) begin
        if (start_hit) begin
          idx_nxt  = 8'd1;
          len_nxt  = 8'd0;
          cmd_nxt  = 8'd0;
          sum_nxt  = 16'd0;
          rsum_nxt = 16'd0;
          for (int i = 0; i < s16fr_pkg::CAP_DEPTH; i++) begin
            cap_nxt[i] = 8'd0;
          end
        end
      end else begin
        if (in_cap) begin
          cap_nxt[cap_idx] = byte_i;
        end
        if (idx_r == s16fr_pkg::POS_COMMAND) begin
          cmd_nxt = byte_i;
        end
        if (idx_r == s16fr_pkg::POS_LENGTH) begin
          len_nxt = byte_i;
        end
        // Sum over bytes 1..4+N, then the received sum low byte first
        priority if (pos9 >= 9'd1 && pos9 <= n9 + 9'd4) begin
          sum_nxt = sum_r + {8'd0, byte_i};
        end else if (pos9 == n9 + 9'd5) begin
          rsum_nxt = {rsum_r[15:8], byte_i};
        end else if (pos9 == n9 + 9'd6) begin
          rsum_nxt = {byte_i, rsum_r[7:0]};
        end else begin
          rsum_nxt = rsum_r;
        end
        if (size_err || frame_end) begin
          idx_nxt = 8'd0;
        end else begin
          idx_nxt = idx_r + 8'd1;
        end
      end
    end
  end

  // Result for the byte at hand
  always_comb begin
    res_valid_o = step_i && (size_err || frame_end);
    res_o       = '0;
    if (size_err) begin
      res_o.frame_status = s16fr_pkg::STATUS_SIZE_ERR;
    end else if (sum_nxt != rsum_nxt) begin
      res_o.frame_status = s16fr_pkg::STATUS_CSUM_ERR;
      res_o.command_code = cmd_nxt;
    end else if (cmd_nxt == s16fr_pkg::CMD_OPERATION) begin
      res_o.frame_status    = s16fr_pkg::STATUS_DECODED;
      res_o.command_code    = cmd_nxt;
      res_o.battery_low     = (cap_nxt[0] == s16fr_pkg::BATTERY_LOW_CODE);
      res_o.current_tenths  = {cap_nxt[2], cap_nxt[1]};
      res_o.wheel_period_ms = {cap_nxt[4], cap_nxt[3]};
      res_o.fault_code      = cap_nxt[5];
    end else begin
      res_o.frame_status = s16fr_pkg::STATUS_OTHER;
      res_o.command_code = cmd_nxt;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= s16fr_pkg::PH_HUNT;
      idx_r   <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Frame data, all set at each start code
  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    cmd_r  <= cmd_nxt;
    sum_r  <= sum_nxt;
    rsum_r <= rsum_nxt;
    cap_r  <= cap_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/s16fr_out_stage.sv
// Result register of the sum16 frame receiver with valid/ready output.
// Depends on s16fr_pkg for the result type.
`default_nettype none

module s16fr_out_stage (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load_i,
  input  wire s16fr_pkg::result_t res_i,
  output logic             free_o,
  output logic             out_valid,
  input  wire logic        out_ready,
  output s16fr_pkg::result_t res_o
);

  logic               vld_r;
  logic               vld_nxt;
  s16fr_pkg::result_t res_r;

  // Can take a new result when empty or when drained this cycle
  assign free_o = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load_i) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      res_r <= res_i;
    end
  end

  assign out_valid = vld_r;
  assign res_o     = res_r;

endmodule

`default_nettype wire

### rtl/core/s16fr_checker.sv
// Port-level checker for the sum16 frame receiver, bound to the top level.
// Depends on s16fr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module s16fr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_frame_status,
  input wire logic [7:0]  out_command_code,
  input wire logic        out_battery_low,
  input wire logic [15:0] out_current_tenths,
  input wire logic [15:0] out_wheel_period_ms,
  input wire logic [7:0]  out_fault_code
);

  logic decoded;
  logic size_err;
  logic fields_zero;

  assign decoded     = (out_frame_status == s16fr_pkg::STATUS_DECODED);
  assign size_err    = (out_frame_status == s16fr_pkg::STATUS_SIZE_ERR);
  assign fields_zero = !out_battery_low && (out_current_tenths == 16'd0) &&
                       (out_wheel_period_ms == 16'd0) && (out_fault_code == 8'd0);

  // A stalled result holds
  `S16_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_frame_status) && $stable(out_command_code) && $stable(out_current_tenths))
  // Data fields are only set on a decoded operation frame
  `S16_ASSERT_IMPLY(a_fields_zero, clk, rst_n, out_valid && !decoded, fields_zero)
  // Size errors carry no command
  `S16_ASSERT_IMPLY(a_size_cmd, clk, rst_n, out_valid && size_err, out_command_code == 8'd0)
  // Only the operation command is decoded
  `S16_ASSERT_IMPLY(a_dec_cmd, clk, rst_n, out_valid && decoded, out_command_code == s16fr_pkg::CMD_OPERATION)

endmodule

bind sum16_frame_receiver_decoder s16fr_checker u_s16fr_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_frame_status    (out_frame_status),
  .out_command_code    (out_command_code),
  .out_battery_low     (out_battery_low),
  .out_current_tenths  (out_current_tenths),
  .out_wheel_period_ms (out_wheel_period_ms),
  .out_fault_code      (out_fault_code)
);

`default_nettype wire

### tb/sum16_frame_receiver_decoder_test.sv
// Self-checking bench for the sum16 frame receiver: directed frames, then random
// framed byte streams, with results checked against a cycle-free frame predictor.
// Depends on s16fr_pkg and sum16_frame_receiver_decoder.
`default_nettype none

module sum16_frame_receiver_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_FRAME   = 64;
  localparam int MAX_DATA    = MAX_FRAME - 9;
  localparam int ITEM_TARGET = 1650;

  // One row of the directed table: a byte, and optionally the result it closes
  typedef struct packed {
    logic [7:0]         rx;
    logic               typed;
    s16fr_pkg::result_t want;
  } byte_row_t;

  localparam s16fr_pkg::result_t NO_RESULT = '0;

  localparam byte_row_t DIRECTED_ROWS [24] = '{
    // noise while hunting
    '{8'h00, 1'b0, NO_RESULT},
    // oversized length at the length byte
    '{8'h3A, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'h52, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1,
      '{s16fr_pkg::STATUS_SIZE_ERR, 8'h00, 1'b0, 16'h0000, 16'h0000, 8'h00}},
    // empty operation frame, start code as source byte, decode reads sum/trailer
    '{8'h3A, 1'b0, NO_RESULT},
    '{8'h3A, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, NO_RESULT},
    '{8'h52, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h8D, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h40, 1'b0, NO_RESULT},
    '{8'h0A, 1'b0, NO_RESULT},
    // all-ones frame with a bad sum
    '{8'h3A, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1,
      '{s16fr_pkg::STATUS_CSUM_ERR, 8'hFF, 1'b0, 16'h0000, 16'h0000, 8'h00}}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_frame_status;
  logic [7:0]  out_command_code;
  logic        out_battery_low;
  logic [15:0] out_current_tenths;
  logic [15:0] out_wheel_period_ms;
  logic [7:0]  out_fault_code;

  sum16_frame_receiver_decoder #(
    .MAX_FRAME(MAX_FRAME)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_frame_status    (out_frame_status),
    .out_command_code    (out_command_code),
    .out_battery_low     (out_battery_low),
    .out_current_tenths  (out_current_tenths),
    .out_wheel_period_ms (out_wheel_period_ms),
    .out_fault_code      (out_fault_code)
  );

  // Predictor copy of the receiver state
  s16fr_pkg::phase_t rx_phase;
  logic [7:0]        rx_pos;
  logic [7:0]        rx_len;
  logic [7:0]        rx_cmd;
  logic [15:0]       rx_sum;
  logic [15:0]       rx_csum;
  logic [7:0]        rx_cap [s16fr_pkg::CAP_DEPTH];

  s16fr_pkg::result_t pending_results [$];
  int                 fail_count;
  int                 items_done;
  int                 status_seen [4];
  bit                 calm;

  // Monitor sampling
  bit                 take;
  s16fr_pkg::result_t got;
  s16fr_pkg::result_t want;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("tb: failure");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [15:0] got_v,
                               input logic [15:0] want_v);
    $display("%0t ns mismatch %s: got %0h want %0h", $realtime, what, got_v, want_v);
    fail_count++;
  endtask

  task automatic clear_receiver();
    rx_phase = s16fr_pkg::PH_HUNT;
    rx_pos   = '0;
    rx_len   = '0;
    rx_cmd   = '0;
    rx_sum   = '0;
    rx_csum  = '0;
    foreach (rx_cap[i]) rx_cap[i] = '0;
  endtask

  // Advance the predictor by one byte; flags bytes dropped while hunting
  task automatic decode_frame_byte(input logic [7:0] b, output bit ignored,
                                   output bit has_res, output s16fr_pkg::result_t res);
    int pos;
    int n;
    ignored = 1'b0;
    has_res = 1'b0;
    res     = '0;
    if (rx_phase == s16fr_pkg::PH_HUNT) begin
      if (b == s16fr_pkg::START_CODE) begin
        clear_receiver();
        rx_phase = s16fr_pkg::PH_FRAME;
        rx_pos   = 8'd1;
      end else begin
        ignored = 1'b1;
      end
      return;
    end
    pos = rx_pos;
    n   = rx_len;
    if (pos >= s16fr_pkg::CAP_FIRST_POS && pos <= s16fr_pkg::CAP_LAST_POS)
      rx_cap[pos - s16fr_pkg::CAP_FIRST_POS] = b;
    if (pos == s16fr_pkg::POS_COMMAND) rx_cmd = b;
    if (pos == s16fr_pkg::POS_LENGTH) begin
      rx_len = b;
      n      = b;
      if (n > MAX_DATA) begin
        rx_phase         = s16fr_pkg::PH_HUNT;
        rx_pos           = '0;
        has_res          = 1'b1;
        res.frame_status = s16fr_pkg::STATUS_SIZE_ERR;
        return;
      end
    end
    // sum covers bytes 1..4+N, then the received sum arrives low byte first
    if (pos <= 4 + n) rx_sum = rx_sum + 16'(b);
    else if (pos == 5 + n) rx_csum[7:0] = b;
    else if (pos == 6 + n) rx_csum[15:8] = b;
    if (pos >= 8 + n) begin
      rx_phase         = s16fr_pkg::PH_HUNT;
      rx_pos           = '0;
      has_res          = 1'b1;
      res.command_code = rx_cmd;
      if (rx_sum != rx_csum) begin
        res.frame_status = s16fr_pkg::STATUS_CSUM_ERR;
      end else if (rx_cmd == s16fr_pkg::CMD_OPERATION) begin
        res.frame_status    = s16fr_pkg::STATUS_DECODED;
        res.battery_low     = (rx_cap[0] == s16fr_pkg::BATTERY_LOW_CODE);
        res.current_tenths  = {rx_cap[2], rx_cap[1]};
        res.wheel_period_ms = {rx_cap[4], rx_cap[3]};
        res.fault_code      = rx_cap[5];
      end else begin
        res.frame_status = s16fr_pkg::STATUS_OTHER;
      end
      return;
    end
    rx_pos = 8'(pos + 1);
  endtask

  // One input transfer with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic typed,
                           input s16fr_pkg::result_t fixed);
    bit                 ignored;
    bit                 has_res;
    s16fr_pkg::result_t res;
    while (!calm && $urandom_range(0, 99) < 12) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    forever begin
      #0.5;
      if (in_ready) break;
      @(negedge clk);
    end
    @(posedge clk);
    decode_frame_byte(b, ignored, has_res, res);
    if (!ignored) items_done++;
    if (typed) pending_results.push_back(fixed);
    else if (has_res) pending_results.push_back(res);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] random_noise();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == s16fr_pkg::START_CODE);
    return v;
  endfunction

  // Mostly well-formed frames with random content; some bad sums, oversized
  // lengths and bursts of raw bytes that may open frames of their own
  task automatic send_random_frame();
    logic [7:0]  frame_bytes [$];
    logic [7:0]  b;
    logic [15:0] csum;
    int          n;
    int          pick;
    if ($urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 10)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
    repeat ($urandom_range(0, 2)) frame_bytes.push_back(random_noise());
    pick = $urandom_range(0, 99);
    if (pick < 70)      n = $urandom_range(0, 8);
    else if (pick < 85) n = $urandom_range(9, MAX_DATA - 1);
    else if (pick < 92) n = MAX_DATA;
    else if (pick < 96) n = MAX_DATA + 1;
    else                n = $urandom_range(MAX_DATA + 1, 255);
    frame_bytes.push_back(s16fr_pkg::START_CODE);
    csum = '0;
    for (int i = 1; i <= 4 + n && i <= s16fr_pkg::POS_LENGTH + MAX_DATA; i++) begin
      if (i == s16fr_pkg::POS_COMMAND)
        b = ($urandom_range(0, 1) != 0) ? s16fr_pkg::CMD_OPERATION
                                        : 8'($urandom_range(0, 255));
      else if (i == s16fr_pkg::POS_LENGTH)
        b = 8'(n);
      else if (i == s16fr_pkg::CAP_FIRST_POS && $urandom_range(0, 99) < 30)
        b = s16fr_pkg::BATTERY_LOW_CODE;
      else
        b = 8'($urandom_range(0, 255));
      frame_bytes.push_back(b);
      csum = csum + 16'(b);
      if (i == s16fr_pkg::POS_LENGTH && n > MAX_DATA) break;
    end
    if (n <= MAX_DATA) begin
      if ($urandom_range(0, 99) < 15) csum = csum ^ 16'($urandom_range(1, 65535));
      frame_bytes.push_back(csum[7:0]);
      frame_bytes.push_back(csum[15:8]);
      frame_bytes.push_back(8'($urandom_range(0, 255)));
      frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], 1'b0, NO_RESULT);
  endtask

  // Result side: random stalls, fields latched just ahead of the rising edge
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= calm || ($urandom_range(0, 99) >= 12);
      #0.5;
      take = out_valid && out_ready && rst_n;
      got  = {out_frame_status, out_command_code, out_battery_low, out_current_tenths,
              out_wheel_period_ms, out_fault_code};
      @(posedge clk);
      if (take) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("result with nothing pending", 16'(got.frame_status), 16'h0);
        end else begin
          want = pending_results.pop_front();
          status_seen[want.frame_status]++;
          if (got.frame_status != want.frame_status)
            flag_mismatch("frame_status", 16'(got.frame_status),
                          16'(want.frame_status));
          if (got.command_code != want.command_code)
            flag_mismatch("command_code", 16'(got.command_code),
                          16'(want.command_code));
          if (got.battery_low != want.battery_low)
            flag_mismatch("battery_low", 16'(got.battery_low), 16'(want.battery_low));
          if (got.current_tenths != want.current_tenths)
            flag_mismatch("current_tenths", got.current_tenths, want.current_tenths);
          if (got.wheel_period_ms != want.wheel_period_ms)
            flag_mismatch("wheel_period_ms", got.wheel_period_ms, want.wheel_period_ms);
          if (got.fault_code != want.fault_code)
            flag_mismatch("fault_code", 16'(got.fault_code), 16'(want.fault_code));
        end
      end
    end
  end

  // Main sequence
  initial begin
    bit paused;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    calm       = 1'b0;
    paused     = 1'b0;
    fail_count = 0;
    items_done = 0;
    clear_receiver();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[i])
      send_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    drain_results();

    while (items_done < ITEM_TARGET) begin
      calm = (items_done >= 700 && items_done < 1000);
      if (!paused && items_done >= 1300) begin
        paused = 1'b1;
        drain_results();
      end
      send_random_frame();
    end
    calm = 1'b0;

    drain_results();
    repeat (20) @(negedge clk);

    $display("covered %0d frame bytes; results: %0d decoded, %0d other command,",
             items_done, status_seen[s16fr_pkg::STATUS_DECODED],
             status_seen[s16fr_pkg::STATUS_OTHER]);
    $display("  %0d checksum errors, %0d size errors",
             status_seen[s16fr_pkg::STATUS_CSUM_ERR],
             status_seen[s16fr_pkg::STATUS_SIZE_ERR]);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
